FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: src/macd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package macd_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_FAST   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_SLOW   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_SIGNAL = 2'd2;

   // default ema periods, alpha = 2 / (n + 1)
   localparam int FAST_PERIOD   = 12;
   localparam int SLOW_PERIOD   = 26;
   localparam int SIGNAL_PERIOD = 9;

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_TWO  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FAST,
      ST_SLOW,
      ST_DIFF,
      ST_SIGNAL,
      ST_UPD_SIG,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_FAST,
      MUL_SLOW,
      MUL_SIGNAL
   } mul_sel_type;

   typedef struct packed {
      logic        first_load;
      logic        load_in;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        upd_fast;
      logic        upd_slow;
      logic        seed_sig;
      logic        upd_sig;
      logic        load_out;
   } cmd_type;

endpackage
`default_nettype wire

FILE: src/macd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module macd_datapath import macd_pkg::*; #(
   parameter int PRICE_WIDTH    = 32,
   parameter int COEF_FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [COEF_FRAC_BITS:0]      csr_wdata,
   input  wire logic [PRICE_WIDTH-1:0]       price_in,
   input  wire cmd_type                      cmd,
   output logic      [PRICE_WIDTH:0]         dif_out,
   output logic      [PRICE_WIDTH:0]         dea_out,
   output logic      [PRICE_WIDTH+1:0]       hist_out
);

   localparam int AW  = COEF_FRAC_BITS + 1;
   localparam int DW  = PRICE_WIDTH + 2;
   localparam int MW  = COEF_FRAC_BITS + 2;
   localparam int PRW = DW + MW;
   localparam logic [AW-1:0] ALPHA_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};
   localparam logic [AW-1:0] ALPHA_FAST_RST   =
      AW'((1 << (COEF_FRAC_BITS + 1)) / (FAST_PERIOD + 1));
   localparam logic [AW-1:0] ALPHA_SLOW_RST   =
      AW'((1 << (COEF_FRAC_BITS + 1)) / (SLOW_PERIOD + 1));
   localparam logic [AW-1:0] ALPHA_SIGNAL_RST =
      AW'((1 << (COEF_FRAC_BITS + 1)) / (SIGNAL_PERIOD + 1));

   logic [AW-1:0]            alpha_fast_ff, alpha_fast_in;
   logic [AW-1:0]            alpha_slow_ff, alpha_slow_in;
   logic [AW-1:0]            alpha_sig_ff, alpha_sig_in;
   logic [PRICE_WIDTH-1:0]   price_ff, price_in_nx;
   logic [PRICE_WIDTH-1:0]   fast_ff, fast_in;
   logic [PRICE_WIDTH-1:0]   slow_ff, slow_in;
   logic [PRICE_WIDTH:0]     sig_ff, sig_in;
   logic [PRICE_WIDTH:0]     dif_ff, dif_in;
   logic signed [PRW-1:0]    prod_ff, prod_in;
   logic [PRICE_WIDTH:0]     dif_out_ff, dif_out_in;
   logic [PRICE_WIDTH:0]     dea_out_ff, dea_out_in;
   logic [PRICE_WIDTH+1:0]   hist_out_ff, hist_out_in;

   logic signed [DW-1:0]     mul_a;
   logic [AW-1:0]            alpha_sel;
   logic [AW-1:0]            alpha_clip;
   logic signed [PRW-1:0]    step_full;
   logic signed [DW-1:0]     step;
   logic signed [DW-1:0]     fast_sum;
   logic signed [DW-1:0]     slow_sum;
   logic signed [DW-1:0]     sig_sum;
   logic [PRICE_WIDTH+1:0]   hist_calc;

   // config registers
   always_comb begin
      alpha_fast_in = alpha_fast_ff;
      alpha_slow_in = alpha_slow_ff;
      alpha_sig_in  = alpha_sig_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALPHA_FAST:   alpha_fast_in = csr_wdata;
            CSR_ALPHA_SLOW:   alpha_slow_in = csr_wdata;
            CSR_ALPHA_SIGNAL: alpha_sig_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_FAST: begin
            mul_a     = signed'({2'b00, price_ff}) - signed'({2'b00, fast_ff});
            alpha_sel = alpha_fast_ff;
         end
         MUL_SLOW: begin
            mul_a     = signed'({2'b00, price_ff}) - signed'({2'b00, slow_ff});
            alpha_sel = alpha_slow_ff;
         end
         default: begin
            mul_a     = signed'({dif_ff[PRICE_WIDTH], dif_ff})
                      - signed'({sig_ff[PRICE_WIDTH], sig_ff});
            alpha_sel = alpha_sig_ff;
         end
      endcase
      alpha_clip = (alpha_sel > ALPHA_ONE) ? ALPHA_ONE : alpha_sel;
   end

   assign prod_in   = cmd.mul_en ? (mul_a * signed'({1'b0, alpha_clip})) : prod_ff;
   // arithmetic shift floors toward minus infinity
   assign step_full = prod_ff >>> COEF_FRAC_BITS;
   assign step      = step_full[DW-1:0];
   assign fast_sum  = signed'({2'b00, fast_ff}) + step;
   assign slow_sum  = signed'({2'b00, slow_ff}) + step;
   assign sig_sum   = signed'({sig_ff[PRICE_WIDTH], sig_ff}) + step;
   assign hist_calc = {dif_ff[PRICE_WIDTH], dif_ff} - {sig_ff[PRICE_WIDTH], sig_ff};

   always_comb begin
      price_in_nx = price_ff;
      fast_in     = fast_ff;
      slow_in     = slow_ff;
      sig_in      = sig_ff;
      dif_in      = dif_ff;
      dif_out_in  = dif_out_ff;
      dea_out_in  = dea_out_ff;
      hist_out_in = hist_out_ff;
      if (cmd.first_load) begin
         fast_in = price_in;
         slow_in = price_in;
         sig_in  = '0;
         dif_in  = '0;
      end
      if (cmd.load_in) begin
         price_in_nx = price_in;
      end
      if (cmd.upd_fast) begin
         fast_in = fast_sum[PRICE_WIDTH-1:0];
      end
      if (cmd.upd_slow) begin
         slow_in = slow_sum[PRICE_WIDTH-1:0];
         dif_in  = {1'b0, fast_ff} - {1'b0, slow_sum[PRICE_WIDTH-1:0]};
      end
      if (cmd.seed_sig) begin
         sig_in = dif_ff;
      end
      if (cmd.upd_sig) begin
         sig_in = sig_sum[PRICE_WIDTH:0];
      end
      if (cmd.load_out) begin
         dif_out_in  = dif_ff;
         dea_out_in  = sig_ff;
         hist_out_in = hist_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_fast_ff <= ALPHA_FAST_RST;
         alpha_slow_ff <= ALPHA_SLOW_RST;
         alpha_sig_ff  <= ALPHA_SIGNAL_RST;
      end else begin
         alpha_fast_ff <= alpha_fast_in;
         alpha_slow_ff <= alpha_slow_in;
         alpha_sig_ff  <= alpha_sig_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff    <= price_in_nx;
      fast_ff     <= fast_in;
      slow_ff     <= slow_in;
      sig_ff      <= sig_in;
      dif_ff      <= dif_in;
      prod_ff     <= prod_in;
      dif_out_ff  <= dif_out_in;
      dea_out_ff  <= dea_out_in;
      hist_out_ff <= hist_out_in;
   end

   assign dif_out  = dif_out_ff;
   assign dea_out  = dea_out_ff;
   assign hist_out = hist_out_ff;

endmodule
`default_nettype wire

FILE: src/macd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module macd_ctrl import macd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  wire logic req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output cmd_type   cmd
);

   state_type  state_ff, state_in;
   logic [1:0] samples_ff, samples_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         samples_ff   <= SEEN_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         samples_ff   <= samples_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      samples_in   = samples_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser || samples_ff == SEEN_NONE) begin
                  cmd.first_load = 1'b1;
                  samples_in     = SEEN_ONE;
                  state_in       = ST_FINISH;
               end else begin
                  cmd.load_in = 1'b1;
                  state_in    = ST_FAST;
               end
            end
         end
         ST_FAST: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_FAST;
            state_in    = ST_SLOW;
         end
         ST_SLOW: begin
            cmd.upd_fast = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_SLOW;
            state_in     = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.upd_slow = 1'b1;
            state_in     = ST_SIGNAL;
         end
         ST_SIGNAL: begin
            if (samples_ff == SEEN_ONE) begin
               cmd.seed_sig = 1'b1;
               samples_in   = SEEN_TWO;
               state_in     = ST_FINISH;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_SIGNAL;
               state_in    = ST_UPD_SIG;
            end
         end
         ST_UPD_SIG: begin
            cmd.upd_sig = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_CLK(a_load_out_free, clock, reset, cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
   `ASSERT_NEVER(a_samples_sat, clock, reset, samples_ff == 2'd3)
   `ASSERT_CLK(a_accept_next, clock, reset, (req_tvalid && req_tready) |=> (state_ff == ST_FAST || state_ff == ST_FINISH))
   `ASSERT_CLK(a_seed_once, clock, reset, cmd.seed_sig |-> samples_ff == SEEN_ONE)

endmodule
`default_nettype wire

FILE: src/macd_indicator.sv
`timescale 1ns / 1ps
`default_nettype none
// macd indicator: fast, slow and signal ema of a closing price stream
// request channel: req_tdata carries close_price (unsigned q16.16), req_tuser
//   marks the first bar of a new series; one request in flight at a time
// response channel: one response per request with dif, dea and histogram
// csr port: csr_wr_en / csr_index / csr_wdata write alpha_fast (0),
//   alpha_slow (1) and alpha_signal (2) in q1.16; write only while idle
// after accept, a normal sample steps through fast, slow, diff, signal, upd_sig
//   and finish; the second sample of a series seeds dea in signal, skips upd_sig,
//   and the first goes straight to finish; a new request is taken only in idle,
//   as the three ema updates share one multiplier in turn
// reset: alphas return to periods 12, 26 and 9; the next request starts a
//   new series whatever req_tuser says
// stall: the response register holds while rsp_tready is low and a new
//   request may still be accepted; its result waits until the register frees
module macd_indicator import macd_pkg::*; #(
   parameter int PRICE_WIDTH    = 32,
   parameter int COEF_FRAC_BITS = 16,
   localparam int REQ_W = ((PRICE_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((3 * PRICE_WIDTH + 4 + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_W-1:0]       req_tdata,  // close_price
   input  wire logic                   req_tuser,  // start_of_series
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_W-1:0]       rsp_tdata,  // dif_value, dea_value, histogram
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COEF_FRAC_BITS:0] csr_wdata
);

   cmd_type                cmd;
   logic [PRICE_WIDTH:0]   dif_value;
   logic [PRICE_WIDTH:0]   dea_value;
   logic [PRICE_WIDTH+1:0] histogram;

   macd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   macd_datapath #(
      .PRICE_WIDTH    (PRICE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .price_in  (req_tdata[PRICE_WIDTH-1:0]),
      .cmd       (cmd),
      .dif_out   (dif_value),
      .dea_out   (dea_value),
      .hist_out  (histogram)
   );

   assign rsp_tdata = RSP_W'({histogram, dea_value, dif_value});

endmodule
`default_nettype wire
